[rtl/sag_pkg.sv]
package sag_pkg;

  localparam int unsigned DEF_MAX_DIMS  = 4;
  localparam int unsigned DEF_ADDR_BITS = 32;
  localparam int unsigned HW_DIMS       = 4;
  localparam int unsigned IDX_W         = 32;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned STRIDE_W      = 32;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_OFFSET = 3'd0,
    REG_SIZE_DIM1   = 3'd1,
    REG_SIZE_DIM2   = 3'd2,
    REG_SIZE_DIM3   = 3'd3,
    REG_STRIDE_DIM0 = 3'd4,
    REG_STRIDE_DIM1 = 3'd5,
    REG_STRIDE_DIM2 = 3'd6,
    REG_STRIDE_DIM3 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] element_index;
    logic             is_final;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]      source_address;
    logic [IDX_W-1:0] dest_index;
    logic             final_res;
  } out_beat_t;

endpackage

[rtl/sag_divcell.sv]
// one bit of restoring division per cell: quotient bit and partial remainder
module sag_divcell (
  input  logic [sag_pkg::SIZE_W-1:0] divisor,
  input  logic [sag_pkg::SIZE_W-1:0] rem_in,
  input  logic                       dividend_bit,
  output logic [sag_pkg::SIZE_W-1:0] rem_out,
  output logic                       q_bit
);
  import sag_pkg::*;

  logic [SIZE_W:0] trial;
  logic [SIZE_W:0] diff;

  always_comb begin
    trial   = {rem_in, dividend_bit};
    diff    = trial - {1'b0, divisor};
    q_bit   = (trial >= {1'b0, divisor});
    rem_out = q_bit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
  end
endmodule

[rtl/sag_cell.sv]
// one pipeline cell: STEPS division bits of one dimension, registered
module sag_cell #(
  parameter int unsigned STEPS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_in,
  input  logic [sag_pkg::SIZE_W-1:0]   divisor,
  input  logic [sag_pkg::IDX_W-1:0]    num_in,
  input  logic [sag_pkg::SIZE_W-1:0]   rem_in,
  input  logic [sag_pkg::IDX_W-1:0]    quo_in,
  input  sag_pkg::in_beat_t            beat_in,
  input  logic [sag_pkg::STRIDE_W-1:0] acc_in,
  output logic                         vld_out,
  output logic [sag_pkg::IDX_W-1:0]    num_out,
  output logic [sag_pkg::SIZE_W-1:0]   rem_out,
  output logic [sag_pkg::IDX_W-1:0]    quo_out,
  output sag_pkg::in_beat_t            beat_out,
  output logic [sag_pkg::STRIDE_W-1:0] acc_out
);
  import sag_pkg::*;

  logic [SIZE_W-1:0] r [STEPS+1];
  logic [STEPS-1:0]  q;
  logic [IDX_W-1:0]  num_shift;
  logic [IDX_W-1:0]  quo_nxt;

  assign r[0] = rem_in;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    sag_divcell u_bit (
      .divisor     (divisor),
      .rem_in      (r[s]),
      .dividend_bit(num_in[IDX_W-1-s]),
      .rem_out     (r[s+1]),
      .q_bit       (q[STEPS-1-s])
    );
  end

  always_comb begin
    num_shift = num_in << STEPS;
    quo_nxt   = {quo_in[IDX_W-STEPS-1:0], q};
  end

  logic                vld_r;
  logic [IDX_W-1:0]    num_r;
  logic [SIZE_W-1:0]   rem_r;
  logic [IDX_W-1:0]    quo_r;
  in_beat_t            beat_r;
  logic [STRIDE_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    num_r  <= num_shift;
    rem_r  <= r[STEPS];
    quo_r  <= quo_nxt;
    beat_r <= beat_in;
    acc_r  <= acc_in;
  end

  assign vld_out  = vld_r;
  assign num_out  = num_r;
  assign rem_out  = rem_r;
  assign quo_out  = quo_r;
  assign beat_out = beat_r;
  assign acc_out  = acc_r;
endmodule

[rtl/sag_mac.sv]
// multiply-accumulate stage: acc += coord * stride, product registered first
module sag_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_in,
  input  logic [sag_pkg::IDX_W-1:0]    coord,
  input  logic [sag_pkg::STRIDE_W-1:0] stride,
  input  logic [sag_pkg::IDX_W-1:0]    quo_in,
  input  sag_pkg::in_beat_t            beat_in,
  input  logic [sag_pkg::STRIDE_W-1:0] acc_in,
  output logic                         vld_out,
  output logic [sag_pkg::IDX_W-1:0]    quo_out,
  output sag_pkg::in_beat_t            beat_out,
  output logic [sag_pkg::STRIDE_W-1:0] acc_out
);
  import sag_pkg::*;

  logic                vld_a_r, vld_b_r;
  logic [STRIDE_W-1:0] prod_r;
  logic [IDX_W-1:0]    quo_a_r, quo_b_r;
  in_beat_t            beat_a_r, beat_b_r;
  logic [STRIDE_W-1:0] acc_a_r, acc_b_r;
  logic [63:0]         prod_full;

  assign prod_full = 64'(coord) * 64'(stride);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
    end
    prod_r   <= prod_full[STRIDE_W-1:0];
    quo_a_r  <= quo_in;
    beat_a_r <= beat_in;
    acc_a_r  <= acc_in;
    quo_b_r  <= quo_a_r;
    beat_b_r <= beat_a_r;
    acc_b_r  <= acc_a_r + prod_r;
  end

  assign vld_out  = vld_b_r;
  assign quo_out  = quo_b_r;
  assign beat_out = beat_b_r;
  assign acc_out  = acc_b_r;
endmodule

[rtl/strided_address_generator.sv]
// Strided address generator: each start beat carries a linear destination index;
// the block splits it into coordinates (innermost dimension first, by the
// configured extents, extent 0 acting as 1) and emits base_offset plus the sum
// of coordinate times stride, modulo 2^32 and masked to ADDR_BITS bits, with
// the index and final flag echoed. A new beat is taken every cycle (busy is
// always low); each result appears on out_valid for one cycle. Per divided
// dimension there are 4 division cells of 8 bits and a multiply-accumulate
// (product, then sum, registered), and another for the outermost of the NDIMS
// dimensions (MAX_DIMS capped at 4). The receiver cannot stall the block.
// The user must write configuration only while idle; no logic enforces it.
module strided_address_generator #(
  parameter int unsigned MAX_DIMS  = sag_pkg::DEF_MAX_DIMS,
  parameter int unsigned ADDR_BITS = sag_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  sag_pkg::in_beat_t             in_beat,
  output logic                          out_valid,
  output sag_pkg::out_beat_t            out_beat,
  input  logic                          cfg_we,
  input  logic [sag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sag_pkg::CFG_W-1:0]     cfg_wdata
);
  import sag_pkg::*;

  // used dimensions, the outermost one takes the remaining quotient
  localparam int unsigned NDIMS = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
  localparam int unsigned NDIV  = NDIMS - 1;
  localparam int unsigned STEPS = 8;
  localparam int unsigned NCELL = IDX_W / STEPS;
  localparam int unsigned AMASK_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  // configuration registers
  logic [31:0]       base_r;
  logic [SIZE_W-1:0] size_r   [HW_DIMS];   // by k: 0 is dim3
  logic [31:0]       stride_r [HW_DIMS];   // by k: 0 is dim3

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      size_r[0]   <= SIZE_W'(1);
      size_r[1]   <= SIZE_W'(1);
      size_r[2]   <= SIZE_W'(1);
      size_r[3]   <= SIZE_W'(1);
      stride_r[0] <= 32'd1;
      stride_r[1] <= '0;
      stride_r[2] <= '0;
      stride_r[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_OFFSET: base_r      <= cfg_wdata;
        REG_SIZE_DIM1:   size_r[2]   <= cfg_wdata[SIZE_W-1:0];
        REG_SIZE_DIM2:   size_r[1]   <= cfg_wdata[SIZE_W-1:0];
        REG_SIZE_DIM3:   size_r[0]   <= cfg_wdata[SIZE_W-1:0];
        REG_STRIDE_DIM0: stride_r[3] <= cfg_wdata;
        REG_STRIDE_DIM1: stride_r[2] <= cfg_wdata;
        REG_STRIDE_DIM2: stride_r[1] <= cfg_wdata;
        REG_STRIDE_DIM3: stride_r[0] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // chain signals: node 0 is the input, each divided dimension adds NCELL+1 nodes
  localparam int unsigned NNODE = NDIV * (NCELL + 1) + 1;
  logic                vld  [NNODE];
  logic [IDX_W-1:0]    quo  [NNODE];
  in_beat_t            beat [NNODE];
  logic [STRIDE_W-1:0] acc  [NNODE];

  assign vld[0]  = start;
  assign quo[0]  = in_beat.element_index;
  assign beat[0] = in_beat;
  assign acc[0]  = base_r;

  for (genvar d = 0; d < NDIV; d++) begin : g_dim
    localparam int unsigned B = d * (NCELL + 1);
    logic [SIZE_W-1:0] dvs;
    logic [IDX_W-1:0]  num [NCELL+1];
    logic [SIZE_W-1:0] rem [NCELL+1];
    logic [IDX_W-1:0]  qq  [NCELL+1];
    logic              v   [NCELL+1];
    in_beat_t          bt  [NCELL+1];
    logic [STRIDE_W-1:0] ac [NCELL+1];

    assign dvs    = (size_r[d] == '0) ? SIZE_W'(1) : size_r[d];
    assign num[0] = quo[B];
    assign rem[0] = '0;
    assign qq[0]  = '0;
    assign v[0]   = vld[B];
    assign bt[0]  = beat[B];
    assign ac[0]  = acc[B];

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
      sag_cell #(.STEPS(STEPS)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .vld_in(v[c]), .divisor(dvs), .num_in(num[c]), .rem_in(rem[c]),
        .quo_in(qq[c]), .beat_in(bt[c]), .acc_in(ac[c]),
        .vld_out(v[c+1]), .num_out(num[c+1]), .rem_out(rem[c+1]),
        .quo_out(qq[c+1]), .beat_out(bt[c+1]), .acc_out(ac[c+1])
      );
      assign vld[B+c+1]  = v[c+1];
      assign quo[B+c+1]  = qq[c+1];
      assign beat[B+c+1] = bt[c+1];
      assign acc[B+c+1]  = ac[c+1];
    end

    // remainder is the coordinate of this dimension
    sag_mac u_mac (
      .clk(clk), .rst_n(rst_n),
      .vld_in(v[NCELL]), .coord(IDX_W'(rem[NCELL])), .stride(stride_r[d]),
      .quo_in(qq[NCELL]), .beat_in(bt[NCELL]), .acc_in(ac[NCELL]),
      .vld_out(vld[B+NCELL+1]), .quo_out(quo[B+NCELL+1]),
      .beat_out(beat[B+NCELL+1]), .acc_out(acc[B+NCELL+1])
    );
  end

  // outermost used dimension: whole quotient is its coordinate
  logic                vld_f;
  logic [IDX_W-1:0]    quo_f;
  in_beat_t            beat_f;
  logic [STRIDE_W-1:0] acc_f;

  sag_mac u_mac_last (
    .clk(clk), .rst_n(rst_n),
    .vld_in(vld[NNODE-1]), .coord(quo[NNODE-1]), .stride(stride_r[NDIMS-1]),
    .quo_in(quo[NNODE-1]), .beat_in(beat[NNODE-1]), .acc_in(acc[NNODE-1]),
    .vld_out(vld_f), .quo_out(quo_f), .beat_out(beat_f), .acc_out(acc_f)
  );

  logic [31:0] amask;
  assign amask = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << AMASK_W) - 32'd1);

  assign out_valid               = vld_f;
  assign out_beat.source_address = acc_f & amask;
  assign out_beat.dest_index     = beat_f.element_index;
  assign out_beat.final_res      = beat_f.is_final;

  logic unused_quo;
  assign unused_quo = ^quo_f;
endmodule

[rtl/sag_checker.sv]
module sag_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input sag_pkg::in_beat_t  in_beat,
  input sag_pkg::out_beat_t out_beat
);
  import sag_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_no_out_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!start ##20 1'b1) |-> !out_valid)
    else $error("result without a beat");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##20 (out_valid &&
      out_beat.dest_index == $past(in_beat.element_index, 20) &&
      out_beat.final_res == $past(in_beat.is_final, 20)))
    else $error("result missing or mismatched");
endmodule

bind strided_address_generator sag_checker u_sag_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .in_beat(in_beat), .out_beat(out_beat)
);

[dv/sag_checker.sv]
`timescale 1ns / 100ps

module sag_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  sag_pkg::in_beat_t             in_beat,
  input  logic                          out_valid,
  input  sag_pkg::out_beat_t            out_beat,
  input  logic                          cfg_we,
  input  logic [sag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sag_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import sag_pkg::*;

  logic [31:0] base_q, str0_q, str1_q, str2_q, str3_q;
  logic [15:0] sz1_q, sz2_q, sz3_q;
  out_beat_t   addr_queue[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic out_beat_t predict_address(input in_beat_t b);
    logic [31:0] rem, ext, addr;
    out_beat_t   r;
    addr = base_q;
    rem  = b.element_index;
    ext  = (sz3_q == 0) ? 32'd1 : {16'd0, sz3_q};
    addr += (rem % ext) * str3_q;
    rem  = rem / ext;
    ext  = (sz2_q == 0) ? 32'd1 : {16'd0, sz2_q};
    addr += (rem % ext) * str2_q;
    rem  = rem / ext;
    ext  = (sz1_q == 0) ? 32'd1 : {16'd0, sz1_q};
    addr += (rem % ext) * str1_q;
    rem  = rem / ext;
    addr += rem * str0_q;
    r.source_address = addr;
    r.dest_index     = b.element_index;
    r.final_res      = b.is_final;
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = addr_queue.size();

  always @(posedge clk) begin
    out_beat_t w;
    if (!rst_n) begin
      base_q <= '0; sz1_q <= 16'd1; sz2_q <= 16'd1; sz3_q <= 16'd1;
      str0_q <= '0; str1_q <= '0; str2_q <= '0; str3_q <= 32'd1;
      addr_queue.delete();
    end else begin
      if (out_valid) begin
        if (addr_queue.size() == 0) begin
          report("unexpected beat", out_beat.dest_index, '0);
        end else begin
          w = addr_queue.pop_front();
          if (out_beat.source_address !== w.source_address)
            report("source_address", out_beat.source_address, w.source_address);
          if (out_beat.dest_index !== w.dest_index)
            report("dest_index", out_beat.dest_index, w.dest_index);
          if (out_beat.final_res !== w.final_res)
            report("final_res", {31'd0, out_beat.final_res}, {31'd0, w.final_res});
        end
      end
      if (start && !busy) addr_queue.insert(addr_queue.size(), predict_address(in_beat));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_BASE_OFFSET: base_q <= cfg_wdata;
          REG_SIZE_DIM1:   sz1_q  <= cfg_wdata[15:0];
          REG_SIZE_DIM2:   sz2_q  <= cfg_wdata[15:0];
          REG_SIZE_DIM3:   sz3_q  <= cfg_wdata[15:0];
          REG_STRIDE_DIM0: str0_q <= cfg_wdata;
          REG_STRIDE_DIM1: str1_q <= cfg_wdata;
          REG_STRIDE_DIM2: str2_q <= cfg_wdata;
          REG_STRIDE_DIM3: str3_q <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import sag_pkg::*;

  localparam int LATENCY   = 20;
  localparam int WDOG_MAX  = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_beat_t             in_beat = '0;
  logic                 out_valid;
  out_beat_t            out_beat;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   fail_count, pending;
  int                   idle_cycles;
  int                   send_idle_pct;

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  strided_address_generator dut (.*);

  sag_scoreboard u_checker (.*);

  // watchdog: cycles in which no beat moves on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every expected beat has come back, plus pipeline drain
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one start beat; random gaps before it per the current sender idle rate
  task automatic send_beat(input logic [31:0] idx, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= '{element_index: idx, is_final: fin};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [31:0] base, input logic [15:0] s1, input logic [15:0] s2,
                           input logic [15:0] s3, input logic [31:0] t0, input logic [31:0] t1,
                           input logic [31:0] t2, input logic [31:0] t3);
    write_reg(REG_BASE_OFFSET, base);
    write_reg(REG_SIZE_DIM1, {16'd0, s1});
    write_reg(REG_SIZE_DIM2, {16'd0, s2});
    write_reg(REG_SIZE_DIM3, {16'd0, s3});
    write_reg(REG_STRIDE_DIM0, t0);
    write_reg(REG_STRIDE_DIM1, t1);
    write_reg(REG_STRIDE_DIM2, t2);
    write_reg(REG_STRIDE_DIM3, t3);
  endtask

  // small extents mostly, so all coordinates move; sometimes extremes and zero
  function automatic logic [15:0] rand_extent();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 9));
    endcase
  endfunction

  function automatic logic [31:0] rand_stride();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hffffffff;
      2:       return $urandom;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic logic [31:0] rand_index();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'hffffffff - $urandom_range(0, 15);
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  initial begin
    send_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset shape (every index maps to the base offset), then full 4-d shape, then extremes
    send_beat(32'd0, 1'b0);
    send_beat(32'hffffffff, 1'b1);
    send_beat(32'h5a5a5a5a, 1'b0);
    end_burst();
    drain();
    set_shape(32'h1000, 16'd3, 16'd4, 16'd5, 32'd1000, 32'd100, 32'd10, 32'd1);
    for (int i = 0; i < 8; i++) send_beat(32'(i * 7), i[0]);
    send_beat(32'd59, 1'b0);   // last element inside the tensor
    send_beat(32'd60, 1'b0);   // past the tensor: outer coordinate grows
    send_beat(32'hffffffff, 1'b1);
    end_burst();
    drain();
    // zero extents act as one; all-ones strides force wraparound
    set_shape(32'hffffffff, 16'd0, 16'd0, 16'd0, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff);
    send_beat(32'd0, 1'b0);
    send_beat(32'd1, 1'b1);
    send_beat(32'hffffffff, 1'b0);
    end_burst();
    drain();
    set_shape(32'h0, 16'hffff, 16'hffff, 16'hffff, 32'h7, 32'h3, 32'h2, 32'h1);
    send_beat(32'hffffffff, 1'b1);
    send_beat(32'h0001_0000, 1'b0);
    send_beat(32'hfffe_0001, 1'b0);
    end_burst();
    drain();

    // random phases: sender idle rate 13, then 88, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 88 : 0;
      for (int sh = 0; sh < 6; sh++) begin
        set_shape($urandom, rand_extent(), rand_extent(), rand_extent(), rand_stride(),
                  rand_stride(), rand_stride(), rand_stride());
        for (int n = 0; n < 100; n++) begin
          send_beat(rand_index(), 1'($urandom));
          // occasionally hold off until everything in flight has returned
          if ($urandom_range(99) == 0) begin
            end_burst();
            while (pending != 0) @(posedge clk);
          end
        end
        end_burst();
        drain();
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
